### rtl/core/chac_pkg.sv
// ----------------------------------------------------------------------------
// chac_pkg
// Shared types and constants of the convex hull area ratio core.
// ----------------------------------------------------------------------------
package chac_pkg;

	localparam int MAX_POINTS = 64;
	localparam int IDX_W      = 6;
	localparam int CNT_W      = 7;
	localparam int COORD_BITS = 24;
	localparam int DIF_W      = COORD_BITS + 1;
	localparam int UW         = COORD_BITS + 2;
	localparam int FW         = COORD_BITS + 3;
	localparam int MW         = 28;
	localparam int HALF       = MW - 1;
	localparam int PW         = 2 * MW;
	localparam int ACC_W      = 62;
	localparam int AW         = 58;
	localparam int DW         = 2 * HALF;
	localparam int RW         = 98;
	localparam int WRAP_W     = 23;
	localparam int RATIO_W    = 24;
	localparam int NUM_SH     = 34;
	localparam int AREA_W     = 54;
	localparam int DIAG_W     = 49;
	localparam int HCNT_W     = 7;

	localparam int IN_W  = 2 * COORD_BITS;
	localparam int OUT_W = 144;

	localparam int AREA_LSB  = 0;
	localparam int DIAG_LSB  = AREA_LSB + AREA_W;
	localparam int RATIO_LSB = DIAG_LSB + DIAG_W;
	localparam int HCNT_LSB  = RATIO_LSB + RATIO_W;
	localparam int FEW_BIT   = HCNT_LSB + HCNT_W;
	localparam int SAT_BIT   = FEW_BIT + 1;
	localparam int DROP_BIT  = SAT_BIT + 1;

	localparam logic [17:0] PI_Q16 = 18'd205887;
	localparam logic [20:0] FLOOR4 = 21'd1717987;
	localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};
	localparam logic [DIAG_W-1:0] DIAG_MAX = {DIAG_W{1'b1}};
	localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};
	localparam logic [WRAP_W-1:0] WRAP_RESET = 23'd76800;

	localparam logic [4:0] DIV_LAST   = 5'(COORD_BITS - 1);
	localparam logic [4:0] RATIO_LAST = 5'(RATIO_W - 1);

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_TOROIDAL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WRAP     = 1'b1;

	typedef enum logic [5:0] {
		S_LOAD, S_START,
		U_REQ, U_LD, U_DIV, U_FIX, U_WR,
		W_INIT, W_P, W_PD, W_QD, W_ID, W_M2, W_CMP, W_NEXT,
		A_INIT, A_PU, A_PC, A_BU, A_BC, A_ACC, A_END,
		D_OUTER, D_AU, D_AC, D_BU, D_BC, D_M2, D_SUM,
		R_M0, R_M1, R_M2, R_SAT, R_DIV,
		S_DONE
	} state_t;

endpackage

### rtl/core/convex_hull_area_ratio_core.sv
// ----------------------------------------------------------------------------
// convex_hull_area_ratio_core
// Loads a point set, walks its convex hull and reports area, longest
// diagonal and the area ratio to the circle on that diagonal.
// ----------------------------------------------------------------------------
// Points load one per cycle. After the transfer marked last the core is busy
// and takes no point until the set is done. The set then runs through unwrap
// (in toroidal mode an iterative remainder unit works on each axis), hull
// walk, area, diagonal search and ratio division. All products go through one
// 28x28 multiplier; points, unwrapped points and the hull list sit in
// single-port-read memories.
module convex_hull_area_ratio_core
	import chac_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WRAP_W-1:0]    cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_W-1:0]      s_tdata,   // point_x, point_y
	input  logic                 s_tlast,   // last_point
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata    // hull_area, diagonal_sq, area_ratio,
	                                        // hull_vertex_count, too_few_points,
	                                        // ratio_saturated, points_dropped
);

	state_t state_q, state_d;

	logic              tor_q;
	logic [WRAP_W-1:0] wrap_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              ovf_q;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	logic [CNT_W-1:0] n_q;
	logic             drop_q;
	logic             few_q;

	logic [IN_W-1:0]  pts_mem [MAX_POINTS];
	logic [IN_W-1:0]  pts_rd_q;
	logic [2*UW-1:0]  u_mem [MAX_POINTS];
	logic [2*UW-1:0]  u_rd_q;
	logic [IDX_W-1:0] hull_mem [MAX_POINTS];
	logic [IDX_W-1:0] h_rd_q;

	logic [IDX_W-1:0] u_raddr, h_raddr;
	logic             u_we, h_we, pts_we;

	logic [CNT_W-1:0] i_q, j_q, len_q;
	logic [IDX_W-1:0] p_q, q_q, l_q;
	logic signed [UW-1:0] px_q, py_q, qx_q, qy_q, ux_q, uy_q, minx_q;
	logic signed [COORD_BITS-1:0] x0_q, y0_q, base_q;
	logic signed [DIF_W-1:0] d_q;
	logic [COORD_BITS-1:0] mag_q;
	logic [WRAP_W-1:0] rem_q;
	logic neg_q, ax_q;
	logic [4:0] dcnt_q;

	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] mul_p, mp_q, prod1_q, sq1_q, lo_q;
	logic [2*UW-1:0] ac_q, bc_q;
	logic signed [ACC_W-1:0] acc_q, acc_abs;
	logic [AW-1:0] area_q;
	logic [DW-1:0] diag_q, dsum;
	logic [RW-1:0] num_q, top_q, den_v, den_c, tsh;
	logic [RATIO_W-1:0] quo_q;
	logic sat_q;

	logic in_xfer, out_load, cnt_room;
	logic signed [UW-1:0] u_rd_x, u_rd_y, ac_x, ac_y, bc_y;
	logic signed [COORD_BITS-1:0] pts_x, pts_y, ld_crd, ld_base;
	logic signed [DIF_W-1:0] ld_dif;
	logic [DIF_W-1:0] ld_abs;
	logic [COORD_BITS-1:0] div_t;
	logic [WRAP_W-1:0] div_rem;
	logic wrap_on;
	logic signed [FW-1:0] fix_r0, fix_r, fix_w, fix_sum;
	logic signed [PW:0] cmp_d;
	logic cmp_gt;
	logic [CNT_W-1:0] i_nx, j_nx, p_nx, len_m1;
	logic [AREA_W-1:0] out_area;
	logic [DIAG_W-1:0] out_diag;

	assign s_tready = (state_q == S_LOAD);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign in_xfer  = s_tvalid && s_tready;
	assign cnt_room = (cnt_q < CNT_W'(MAX_POINTS));
	assign pts_we   = in_xfer && cnt_room;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || m_tready);

	assign pts_x  = pts_rd_q[COORD_BITS-1:0];
	assign pts_y  = pts_rd_q[IN_W-1:COORD_BITS];
	assign u_rd_x = u_rd_q[UW-1:0];
	assign u_rd_y = u_rd_q[2*UW-1:UW];
	assign ac_x   = ac_q[UW-1:0];
	assign ac_y   = ac_q[2*UW-1:UW];
	assign bc_y   = bc_q[2*UW-1:UW];

	assign i_nx   = i_q + 1'b1;
	assign j_nx   = j_q + 1'b1;
	assign p_nx   = {1'b0, p_q} + 1'b1;
	assign len_m1 = len_q - 1'b1;

	// point unwrap
	assign wrap_on = tor_q && (wrap_q != '0);
	assign ld_crd  = ax_q ? pts_y : pts_x;
	assign ld_base = (i_q == '0) ? ld_crd : (ax_q ? y0_q : x0_q);
	assign ld_dif  = DIF_W'(ld_crd) - DIF_W'(ld_base);
	assign ld_abs  = ld_dif[DIF_W-1] ? DIF_W'(-ld_dif) : DIF_W'(ld_dif);
	assign div_t   = {rem_q, mag_q[COORD_BITS-1]};
	assign div_rem = (div_t >= {1'b0, wrap_q}) ? WRAP_W'(div_t - {1'b0, wrap_q})
	                                           : div_t[WRAP_W-1:0];
	assign fix_w   = FW'({1'b0, wrap_q});

	always_comb begin
		fix_r0 = FW'({1'b0, rem_q});
		if (neg_q) begin
			fix_r0 = -fix_r0;
		end
		if (wrap_on) begin
			fix_r = fix_r0;
			if ((fix_r0 <<< 1) > fix_w) begin
				fix_r = fix_r0 - fix_w;
			end else if ((fix_r0 <<< 1) < -fix_w) begin
				fix_r = fix_r0 + fix_w;
			end
		end else begin
			fix_r = FW'(d_q);
		end
		fix_sum = FW'(base_q) + fix_r;
	end

	// shared multiplier
	assign mul_p = mul_a * mul_b;

	assign cmp_d   = (PW+1)'(prod1_q) - (PW+1)'(mp_q);
	assign cmp_gt  = !cmp_d[PW] && (cmp_d != '0);
	assign acc_abs = acc_q[ACC_W-1] ? -acc_q : acc_q;
	assign dsum    = sq1_q[DW-1:0] + mp_q[DW-1:0];
	assign den_v   = (RW'(mp_q[PW-2:0]) << HALF) + RW'(lo_q[PW-2:0]);
	assign den_c   = (den_v < RW'(FLOOR4)) ? RW'(FLOOR4) : den_v;
	assign tsh     = top_q >> 1;

	assign out_area = (area_q > AW'(AREA_MAX)) ? AREA_MAX : area_q[AREA_W-1:0];
	assign out_diag = (diag_q > DW'(DIAG_MAX)) ? DIAG_MAX : diag_q[DIAG_W-1:0];

	always_comb begin
		state_d = state_q;
		u_raddr = '0;
		h_raddr = '0;
		u_we    = 1'b0;
		h_we    = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		case (state_q)
			S_LOAD: begin
				if (in_xfer && s_tlast) begin
					state_d = S_START;
				end
			end
			S_START: begin
				state_d = (n_q < CNT_W'(3)) ? S_DONE : U_REQ;
			end
			U_REQ: state_d = U_LD;
			U_LD: begin
				state_d = wrap_on ? U_DIV : U_FIX;
			end
			U_DIV: begin
				if (dcnt_q == DIV_LAST) begin
					state_d = U_FIX;
				end
			end
			U_FIX: begin
				state_d = ax_q ? U_WR : U_LD;
			end
			U_WR: begin
				u_we    = 1'b1;
				state_d = (i_nx < n_q) ? U_REQ : W_INIT;
			end
			W_INIT: state_d = W_P;
			W_P: begin
				h_we    = 1'b1;
				u_raddr = p_q;
				state_d = W_PD;
			end
			W_PD: begin
				u_raddr = q_q;
				state_d = W_QD;
			end
			W_QD: begin
				state_d = W_ID;
			end
			W_ID: begin
				u_raddr = i_q[IDX_W-1:0];
				mul_a   = MW'(u_rd_x) - MW'(px_q);
				mul_b   = MW'(qy_q) - MW'(py_q);
				state_d = W_M2;
			end
			W_M2: begin
				u_raddr = i_q[IDX_W-1:0];
				mul_a   = MW'(u_rd_y) - MW'(py_q);
				mul_b   = MW'(qx_q) - MW'(px_q);
				state_d = W_CMP;
			end
			W_CMP: begin
				u_raddr = i_nx[IDX_W-1:0];
				state_d = (i_nx < n_q) ? W_ID : W_NEXT;
			end
			W_NEXT: begin
				if (q_q != l_q && len_q < CNT_W'(MAX_POINTS)) begin
					state_d = W_P;
				end else begin
					state_d = A_INIT;
				end
			end
			A_INIT: begin
				h_raddr = len_m1[IDX_W-1:0];
				state_d = A_PU;
			end
			A_PU: begin
				u_raddr = h_rd_q;
				state_d = A_PC;
			end
			A_PC: begin
				state_d = A_BU;
			end
			A_BU: begin
				u_raddr = h_rd_q;
				state_d = A_BC;
			end
			A_BC: begin
				mul_a   = MW'(ac_x) + MW'(u_rd_x);
				mul_b   = MW'(ac_y) - MW'(u_rd_y);
				state_d = A_ACC;
			end
			A_ACC: begin
				h_raddr = i_nx[IDX_W-1:0];
				state_d = (i_nx < len_q) ? A_BU : A_END;
			end
			A_END: state_d = D_OUTER;
			D_OUTER: begin
				h_raddr = i_q[IDX_W-1:0];
				state_d = ((i_q + CNT_W'(2)) < len_q) ? D_AU : R_M0;
			end
			D_AU: begin
				u_raddr = h_rd_q;
				state_d = D_AC;
			end
			D_AC: begin
				h_raddr = j_q[IDX_W-1:0];
				state_d = D_BU;
			end
			D_BU: begin
				u_raddr = h_rd_q;
				state_d = D_BC;
			end
			D_BC: begin
				mul_a   = MW'(ac_x) - MW'(u_rd_x);
				mul_b   = MW'(ac_x) - MW'(u_rd_x);
				state_d = D_M2;
			end
			D_M2: begin
				mul_a   = MW'(ac_y) - MW'(bc_y);
				mul_b   = MW'(ac_y) - MW'(bc_y);
				state_d = D_SUM;
			end
			D_SUM: begin
				h_raddr = j_nx[IDX_W-1:0];
				state_d = (j_nx < len_q) ? D_BU : D_OUTER;
			end
			R_M0: begin
				mul_a   = {1'b0, diag_q[HALF-1:0]};
				mul_b   = MW'(PI_Q16);
				state_d = R_M1;
			end
			R_M1: begin
				mul_a   = {1'b0, diag_q[DW-1:HALF]};
				mul_b   = MW'(PI_Q16);
				state_d = R_M2;
			end
			R_M2: state_d = R_SAT;
			R_SAT: begin
				state_d = (num_q >= top_q) ? S_DONE : R_DIV;
			end
			R_DIV: begin
				if (dcnt_q == RATIO_LAST) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_LOAD;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			tor_q       <= 1'b0;
			wrap_q      <= WRAP_RESET;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_TOROIDAL: tor_q  <= cfg_data[0];
					CFG_WRAP:     wrap_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_xfer) begin
				if (s_tlast) begin
					cnt_q <= '0;
					ovf_q <= 1'b0;
				end else if (cnt_room) begin
					cnt_q <= cnt_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (pts_we) begin
			pts_mem[cnt_q[IDX_W-1:0]] <= s_tdata;
		end
		pts_rd_q <= pts_mem[i_q[IDX_W-1:0]];
		if (u_we) begin
			u_mem[i_q[IDX_W-1:0]] <= {uy_q, ux_q};
		end
		u_rd_q <= u_mem[u_raddr];
		if (h_we) begin
			hull_mem[len_q[IDX_W-1:0]] <= p_q;
		end
		h_rd_q <= hull_mem[h_raddr];
	end

	// datapath
	always_ff @(posedge clk) begin
		mp_q <= mul_p;
		if (out_load) begin
			out_data_q <= {{(OUT_W-DROP_BIT-1){1'b0}}, drop_q, sat_q, few_q, len_q,
				quo_q, out_diag, out_area};
		end
		case (state_q)
			S_LOAD: begin
				if (in_xfer && s_tlast) begin
					n_q    <= cnt_room ? cnt_q + 1'b1 : cnt_q;
					drop_q <= ovf_q || !cnt_room;
				end
			end
			S_START: begin
				i_q    <= '0;
				ax_q   <= 1'b0;
				area_q <= '0;
				diag_q <= '0;
				quo_q  <= '0;
				sat_q  <= 1'b0;
				len_q  <= '0;
				few_q  <= (n_q < CNT_W'(3));
			end
			U_LD: begin
				if (i_q == '0) begin
					if (ax_q) begin
						y0_q <= ld_crd;
					end else begin
						x0_q <= ld_crd;
					end
				end
				base_q <= ld_base;
				d_q    <= ld_dif;
				mag_q  <= ld_abs[COORD_BITS-1:0];
				neg_q  <= ld_dif[DIF_W-1];
				rem_q  <= '0;
				dcnt_q <= '0;
			end
			U_DIV: begin
				mag_q  <= mag_q << 1;
				rem_q  <= div_rem;
				dcnt_q <= dcnt_q + 1'b1;
			end
			U_FIX: begin
				if (ax_q) begin
					uy_q <= fix_sum[UW-1:0];
				end else begin
					ux_q <= fix_sum[UW-1:0];
				end
				ax_q <= !ax_q;
			end
			U_WR: begin
				if (i_q == '0 || ux_q < minx_q) begin
					minx_q <= ux_q;
					l_q    <= i_q[IDX_W-1:0];
				end
				i_q <= i_nx;
			end
			W_INIT: begin
				p_q   <= l_q;
				len_q <= '0;
			end
			W_P: begin
				len_q <= len_q + 1'b1;
				q_q   <= (p_nx == n_q) ? '0 : p_nx[IDX_W-1:0];
			end
			W_PD: begin
				px_q <= u_rd_x;
				py_q <= u_rd_y;
			end
			W_QD: begin
				qx_q <= u_rd_x;
				qy_q <= u_rd_y;
				i_q  <= '0;
			end
			W_M2: prod1_q <= mp_q;
			W_CMP: begin
				if (cmp_gt) begin
					q_q  <= i_q[IDX_W-1:0];
					qx_q <= u_rd_x;
					qy_q <= u_rd_y;
				end
				i_q <= i_nx;
			end
			W_NEXT: p_q <= q_q;
			A_INIT: acc_q <= '0;
			A_PC: begin
				ac_q <= u_rd_q;
				i_q  <= '0;
			end
			A_BC: bc_q <= u_rd_q;
			A_ACC: begin
				acc_q <= acc_q + ACC_W'(mp_q);
				ac_q  <= bc_q;
				i_q   <= i_nx;
			end
			A_END: begin
				area_q <= acc_abs[AW:1];
				diag_q <= '0;
				i_q    <= '0;
			end
			D_OUTER: j_q <= i_q + CNT_W'(2);
			D_AC: ac_q <= u_rd_q;
			D_BC: bc_q <= u_rd_q;
			D_M2: sq1_q <= mp_q;
			D_SUM: begin
				if (dsum > diag_q) begin
					diag_q <= dsum;
				end
				j_q <= j_nx;
				if (!(j_nx < len_q)) begin
					i_q <= i_nx;
				end
			end
			R_M1: lo_q <= mp_q;
			R_M2: begin
				top_q <= den_c << RATIO_W;
				num_q <= RW'(area_q) << NUM_SH;
			end
			R_SAT: begin
				if (num_q >= top_q) begin
					quo_q <= RATIO_MAX;
					sat_q <= 1'b1;
				end
				dcnt_q <= '0;
			end
			R_DIV: begin
				top_q <= tsh;
				if (num_q >= tsh) begin
					num_q <= num_q - tsh;
					quo_q <= {quo_q[RATIO_W-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[RATIO_W-2:0], 1'b0};
				end
				dcnt_q <= dcnt_q + 1'b1;
			end
			default: ;
		endcase
	end

endmodule

### rtl/core/chac_checker.sv
// ----------------------------------------------------------------------------
// chac_checker
// Port-level checks of the convex hull area ratio core, bound to the top.
// ----------------------------------------------------------------------------
module chac_checker
	import chac_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [WRAP_W-1:0]    cfg_data,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [IN_W-1:0]      s_tdata,
	input logic                 s_tlast,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [OUT_W-1:0]     m_tdata
);

	// busy after the closing point transfer
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("point accepted right after last transfer");

	a_few_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[FEW_BIT] |->
		m_tdata[HCNT_LSB +: HCNT_W] == '0 && m_tdata[AREA_LSB +: AREA_W] == '0)
		else $error("short set reports a hull");

	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[SAT_BIT] |-> m_tdata[RATIO_LSB +: RATIO_W] == RATIO_MAX)
		else $error("saturated ratio not clamped");

	a_hcnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[HCNT_LSB +: HCNT_W] <= HCNT_W'(MAX_POINTS))
		else $error("hull count above store depth");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind convex_hull_area_ratio_core chac_checker u_chac_checker (.*);

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the convex hull area ratio core: point sets are
// streamed in under random gaps and stalls, every hull result is checked
// field by field against an in-bench model of the hull walk and ratio.
// ----------------------------------------------------------------------------
module tb;
	import chac_pkg::*;

	typedef struct {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic                         last;
	} point_t;

	typedef struct packed {
		logic [AREA_W-1:0]  area;
		logic [DIAG_W-1:0]  diag;
		logic [RATIO_W-1:0] ratio;
		logic [HCNT_W-1:0]  cnt;
		logic               few;
		logic               sat;
		logic               drop;
	} hull_res_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WRAP_W-1:0]    cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata;   // point_x, point_y
	logic                 s_tlast;   // last_point
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OUT_W-1:0]     m_tdata;   // hull_area, diagonal_sq, area_ratio,
	                                 // hull_vertex_count, too_few_points,
	                                 // ratio_saturated, points_dropped

	point_t    pending_pts[$];
	hull_res_t hull_expected[$];
	point_t    cur_pt;
	int        send_gap;
	int        recv_stall;
	int        mismatches;
	int        results_seen;
	int        sets_sent;
	int        saturated_seen;
	int        dropped_seen;
	int        idle_cycles;
	int        items_sent;

	// model state
	logic           torus_on;
	logic [22:0]    wrap_len;
	longint         xs[MAX_POINTS];
	longint         ys[MAX_POINTS];
	int             n_loaded;
	logic           overflowed;

	convex_hull_area_ratio_core DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic int draw_wait();
		if ($urandom_range(0, 3) != 0)
			return 0;
		return $urandom_range(0, 10);
	endfunction

	function automatic longint wrap_delta(longint d);
		longint w;
		w = longint'(wrap_len);
		if (!torus_on || w == 0)
			return d;
		d = d % w;
		if (2 * d > w) d -= w;
		if (2 * d < -w) d += w;
		return d;
	endfunction

	function automatic hull_res_t hull_of_set();
		hull_res_t   r;
		longint      ux[MAX_POINTS];
		longint      uy[MAX_POINTS];
		int          hull_idx[MAX_POINTS];
		int          hl, lm, p, q, i, j, a, b;
		logic [63:0] s, ar, dg, d, ta, tb2, te, tf, c, dx, dy;
		logic [127:0] num, den;
		r = '{default: '0};
		r.drop = overflowed;
		if (n_loaded < 3) begin
			r.few = 1'b1;
			return r;
		end
		for (i = 0; i < n_loaded; i++) begin
			if (torus_on) begin
				ux[i] = xs[0] + wrap_delta(xs[i] - xs[0]);
				uy[i] = ys[0] + wrap_delta(ys[i] - ys[0]);
			end else begin
				ux[i] = xs[i];
				uy[i] = ys[i];
			end
		end
		lm = 0;
		for (i = 1; i < n_loaded; i++)
			if (ux[i] < ux[lm]) lm = i;
		hl = 0;
		p = lm;
		do begin
			hull_idx[hl++] = p;
			q = (p + 1) % n_loaded;
			for (i = 0; i < n_loaded; i++) begin
				ta = ux[i] - ux[p];
				tb2 = uy[q] - uy[p];
				te = uy[i] - uy[p];
				tf = ux[q] - ux[p];
				c = ta * tb2 - te * tf;
				if (c != 0 && !c[63]) q = i;
			end
			p = q;
		end while (p != lm && hl < MAX_POINTS);
		s = 0;
		j = hl - 1;
		for (i = 0; i < hl; i++) begin
			a = hull_idx[j];
			b = hull_idx[i];
			ta = ux[a] + ux[b];
			te = uy[a] - uy[b];
			s += ta * te;
			j = i;
		end
		if (s[63]) s = -s;
		ar = s >> 1;
		dg = 0;
		for (i = 0; i < hl; i++)
			for (j = i + 2; j < hl; j++) begin
				dx = ux[hull_idx[i]] - ux[hull_idx[j]];
				dy = uy[hull_idx[i]] - uy[hull_idx[j]];
				d = dx * dx + dy * dy;
				if (d > dg) dg = d;
			end
		num = 128'(ar) << NUM_SH;
		den = 128'(dg) * 128'(PI_Q16);
		if (den < 128'(FLOOR4)) den = 128'(FLOOR4);
		if (num >= (den << 24)) begin
			r.ratio = RATIO_MAX;
			r.sat = 1'b1;
		end else begin
			r.ratio = RATIO_W'(num / den);
		end
		r.area = (ar > 64'(AREA_MAX)) ? AREA_MAX : ar[AREA_W-1:0];
		r.diag = (dg > 64'(DIAG_MAX)) ? DIAG_MAX : dg[DIAG_W-1:0];
		r.cnt = HCNT_W'(hl);
		return r;
	endfunction

	function automatic void take_point(point_t pt);
		if (n_loaded < MAX_POINTS) begin
			xs[n_loaded] = longint'(pt.x);
			ys[n_loaded] = longint'(pt.y);
			n_loaded++;
		end else begin
			overflowed = 1'b1;
		end
		if (pt.last) begin
			hull_expected = {hull_expected, hull_of_set()};
			n_loaded = 0;
			overflowed = 1'b0;
		end
	endfunction

	// point source
	always @(posedge clk or negedge arst_n) begin
		logic took;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
			send_gap = 0;
		end else begin
			took = s_tvalid && s_tready;
			if (took) take_point(cur_pt);
			if (!s_tvalid || took) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_pts.size() > 0) begin
					cur_pt = pending_pts.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {cur_pt.y, cur_pt.x};
					s_tlast <= cur_pt.last;
					send_gap = draw_wait();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result checker
	always @(posedge clk or negedge arst_n) begin
		hull_res_t e, g;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				g.area  = m_tdata[AREA_LSB +: AREA_W];
				g.diag  = m_tdata[DIAG_LSB +: DIAG_W];
				g.ratio = m_tdata[RATIO_LSB +: RATIO_W];
				g.cnt   = m_tdata[HCNT_LSB +: HCNT_W];
				g.few   = m_tdata[FEW_BIT];
				g.sat   = m_tdata[SAT_BIT];
				g.drop  = m_tdata[DROP_BIT];
				results_seen++;
				if (g.sat) saturated_seen++;
				if (g.drop) dropped_seen++;
				if (hull_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %0d: area %0d diag %0d", results_seen,
							g.area, g.diag);
				end else begin
					e = hull_expected.pop_front();
					if (g != e) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("result %0d mismatch", results_seen);
							$display("  exp area %0d diag %0d ratio %0d cnt %0d few %b sat %b drop %b",
								e.area, e.diag, e.ratio, e.cnt, e.few, e.sat, e.drop);
							$display("  got area %0d diag %0d ratio %0d cnt %0d few %b sat %b drop %b",
								g.area, g.diag, g.ratio, g.cnt, g.few, g.sat, g.drop);
						end
					end
				end
				recv_stall = draw_wait();
			end
			if (recv_stall > 0) begin
				recv_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= 300000) begin
			$display("watchdog expired, %0d results outstanding", hull_expected.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic push_pt(int x, int y, logic last);
		point_t p;
		p.x = COORD_BITS'(x);
		p.y = COORD_BITS'(y);
		p.last = last;
		pending_pts = {pending_pts, p};
		items_sent++;
	endtask

	task automatic add_set(int n, int style);
		int bx, by, k, x, y, stp;
		bx = $urandom_range(0, 8000000) - 4000000;
		by = $urandom_range(0, 8000000) - 4000000;
		stp = $urandom_range(1, 3000);
		for (k = 0; k < n; k++) begin
			case (style)
				0: begin
					x = $urandom();
					y = $urandom();
				end
				1: begin
					x = bx + $urandom_range(0, 8000) - 4000;
					y = by + $urandom_range(0, 8000) - 4000;
				end
				2: begin
					x = ($urandom_range(0, 1) != 0) ? 8388607 : -8388608;
					y = ($urandom_range(0, 2) == 0) ? 0 :
						(($urandom_range(0, 1) != 0) ? 8388607 : -8388608);
				end
				3: begin
					x = (k < 2) ? bx : bx + $urandom_range(100000, 4000000);
					y = (k < 2) ? by + k * $urandom_range(0, 3) :
						by + $urandom_range(0, 400) - 200;
				end
				4: begin
					x = $urandom_range(0, 400000) - 200000;
					y = $urandom_range(0, 400000) - 200000;
				end
				default: begin
					x = bx + stp * $urandom_range(0, 5);
					y = ($urandom_range(0, 1) != 0) ? by + stp * $urandom_range(0, 5) : x;
				end
			endcase
			push_pt(x, y, k == n - 1);
		end
		sets_sent++;
	endtask

	task automatic write_regs(logic tor, logic [22:0] wl);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_TOROIDAL;
		cfg_data <= WRAP_W'(tor);
		@(posedge clk);
		cfg_index <= CFG_WRAP;
		cfg_data <= wl;
		@(posedge clk);
		cfg_we <= 1'b0;
		torus_on = tor;
		wrap_len = wl;
	endtask

	task automatic drain();
		while (pending_pts.size() > 0 || s_tvalid || hull_expected.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		logic        tor_v[6];
		logic [22:0] wrap_v[6];
		int          ph, n, r;
		tor_v  = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
		wrap_v = '{23'd76800, 23'd76800, 23'd0, 23'h7FFFFF, 23'd1000, 23'd1};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_TOROIDAL;
		cfg_data = '0;
		torus_on = 1'b0;
		wrap_len = WRAP_RESET;
		n_loaded = 0;
		overflowed = 1'b0;
		mismatches = 0;
		results_seen = 0;
		sets_sent = 0;
		saturated_seen = 0;
		dropped_seen = 0;
		items_sent = 0;
		idle_cycles = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed sets under reset config
		push_pt(5, 5, 1'b1);
		push_pt(-8388608, 8388607, 1'b0);
		push_pt(8388607, -8388608, 1'b1);
		push_pt(0, 0, 1'b0);
		push_pt(100, 100, 1'b0);
		push_pt(200, 200, 1'b1);
		push_pt(-8388608, -8388608, 1'b0);
		push_pt(8388607, -8388608, 1'b0);
		push_pt(8388607, 8388607, 1'b0);
		push_pt(-8388608, 8388607, 1'b1);
		push_pt(0, 0, 1'b0);
		push_pt(0, 2, 1'b0);
		push_pt(8000000, 1, 1'b1);
		push_pt(0, 0, 1'b0);
		push_pt(0, -2, 1'b0);
		push_pt(8000000, -1, 1'b1);
		push_pt(-7, 3, 1'b0);
		push_pt(-7, -4, 1'b0);
		push_pt(2, 0, 1'b0);
		push_pt(-7, 9, 1'b0);
		push_pt(1, 1, 1'b1);
		sets_sent += 7;
		drain();

		for (ph = 0; ph < 6; ph++) begin
			write_regs(tor_v[ph], (ph == 5) ? WRAP_W'($urandom_range(1, 8388607)) : wrap_v[ph]);
			n = 0;
			while (n < 64) begin
				r = $urandom_range(0, 99);
				if (r < 10) begin
					add_set($urandom_range(1, 2), $urandom_range(0, 5));
				end else if (r < 13) begin
					add_set($urandom_range(64, 68), 1);
					n += 60;
				end else if (r < 18) begin
					add_set($urandom_range(13, 30), $urandom_range(0, 5));
					n += 16;
				end else begin
					add_set($urandom_range(3, 10), $urandom_range(0, 5));
				end
				n += 6;
			end
			drain();
		end

		repeat (50) @(posedge clk);
		$display("%0d points in %0d sets over 7 register settings; %0d results checked",
			items_sent, sets_sent, results_seen);
		$display("%0d saturated ratios, %0d sets with dropped points, %0d mismatches",
			saturated_seen, dropped_seen, mismatches);
		if (mismatches == 0 && hull_expected.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### convex_hull_area_ratio_core.f
rtl/core/chac_pkg.sv
rtl/core/convex_hull_area_ratio_core.sv
rtl/core/chac_checker.sv
dv/tb.sv
